// ===== hdl/bounded_int_list_engine_unit_assert.svh =====
// assertion macros for the bounded integer list engine
// no dependencies; included by the top level
`ifndef BOUNDED_INT_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_INT_LIST_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BILE_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("list engine check failed");
`define BILE_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("list engine sequencing check failed");
`else
`define BILE_ASSERT(label, clk, rst, prop)
`define BILE_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif
`endif

// ===== hdl/bile_pkg.sv =====
// shared codes and field widths for the bounded integer list engine
// no dependencies
`default_nettype none
package bile_pkg;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int ELEM_W   = 32;
   localparam int COUNT_W  = 7;

   localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_SORT   = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_READ   = 3'd6;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
endpackage
`default_nettype wire

// ===== hdl/bounded_int_list_engine_unit.sv =====
// Ordered list engine: entries live in a circular buffer in one ram (head pointer + count).
// Append, insert head, pop, clear, unused codes: one registered result in the cycle after the beat.
// Remove and read out: per entry, a ram read step, then a compare/emit step; read out gives one
// result per entry. Sort: entry i against every entry j, at most one ram access per step.
// Synchronous reset empties the list and idles the sequencer; ram contents are not cleared.
// Results cannot be stalled; start is taken only while busy is low.
`default_nettype none
`include "bounded_int_list_engine_unit_assert.svh"
module bounded_int_list_engine_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [bile_pkg::OPCODE_W-1:0]     req_opcode,
   input  wire logic signed [bile_pkg::ELEM_W-1:0] req_operand_value,
   output logic                                   rsp_strobe,
   output logic [bile_pkg::STATUS_W-1:0]          rsp_status,
   output logic signed [bile_pkg::ELEM_W-1:0]     rsp_element_value,
   output logic [bile_pkg::COUNT_W-1:0]           rsp_entry_count,
   output logic                                   rsp_last
);
   import bile_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW:0]   DEPTH_P = (PW+1)'(DEPTH);
   localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_P  = CW'(DEPTH);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RM_RD = 4'd1;
   localparam logic [3:0] S_RM_EX = 4'd2;
   localparam logic [3:0] S_RD_RD = 4'd3;
   localparam logic [3:0] S_RD_EX = 4'd4;
   localparam logic [3:0] S_SO_RI = 4'd5;
   localparam logic [3:0] S_SO_LI = 4'd6;
   localparam logic [3:0] S_SO_RJ = 4'd7;
   localparam logic [3:0] S_SO_EX = 4'd8;
   localparam logic [3:0] S_SO_WB = 4'd9;

   logic [3:0]            state_ff, state_in;
   logic [PW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         i_ff, i_in;
   logic [CW-1:0]         j_ff, j_in;
   logic [CW-1:0]         w_ff, w_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [DATA_WIDTH-1:0] ei_ff, ei_in;
   logic                  valid_ff, valid_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [DATA_WIDTH-1:0] elem_ff, elem_in;
   logic                  last_ff, last_in;

   logic                  wr_en;
   logic [PW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [PW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic                  accept;
   logic signed [63:0]    op_ext;
   logic signed [63:0]    elem_ext;
   logic [63:0]           count_ext;
   logic [PW-1:0]         head_dec;
   logic [PW-1:0]         head_inc;
   logic                  full_beat;
   logic                  walk_cmd;

   // logical list position to ram address
   function automatic logic [PW-1:0] phys(input logic [PW-1:0] base, input logic [PW-1:0] idx);
      logic [PW:0] s;
      s = {1'b0, base} + {1'b0, idx};
      if (s >= DEPTH_P) begin
         s = s - DEPTH_P;
      end
      return s[PW-1:0];
   endfunction

   bile_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign accept   = start && !busy;
   assign busy     = (state_ff != S_IDLE);
   assign op_ext   = 64'(req_operand_value);
   assign head_dec = (head_ff == '0) ? LAST_P : head_ff - PW'(1);
   assign head_inc = (head_ff == LAST_P) ? '0 : head_ff + PW'(1);

   // command sequencer
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      w_in      = w_ff;
      val_in    = val_ff;
      ei_in     = ei_ff;
      valid_in  = 1'b0;
      status_in = ST_OK;
      elem_in   = '0;
      last_in   = 1'b1;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_addr   = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in = op_ext[DATA_WIDTH-1:0];
               i_in   = '0;
               w_in   = '0;
               case (req_opcode)
                  OP_APPEND: begin
                     valid_in = 1'b1;
                     if (count_ff == FULL_P) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = phys(head_ff, count_ff[PW-1:0]);
                        wr_data  = op_ext[DATA_WIDTH-1:0];
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     valid_in = 1'b1;
                     if (count_ff == FULL_P) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = head_dec;
                        wr_data  = op_ext[DATA_WIDTH-1:0];
                        head_in  = head_dec;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_REMOVE: state_in = S_RM_RD;
                  OP_POP: begin
                     valid_in = 1'b1;
                     if (count_ff != '0) begin
                        head_in  = head_inc;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_CLEAR: begin
                     valid_in = 1'b1;
                     count_in = '0;
                  end
                  OP_SORT: state_in = S_SO_RI;
                  OP_READ: begin
                     if (count_ff == '0) begin
                        valid_in  = 1'b1;
                        status_in = ST_EMPTY;
                     end else begin
                        state_in = S_RD_RD;
                     end
                  end
                  default: valid_in = 1'b1;
               endcase
            end
         end
         // remove: compact kept entries toward the head
         S_RM_RD: begin
            if (i_ff == count_ff) begin
               count_in = w_ff;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr  = phys(head_ff, i_ff[PW-1:0]);
               state_in = S_RM_EX;
            end
         end
         S_RM_EX: begin
            if (rd_data != val_ff) begin
               wr_en   = 1'b1;
               wr_addr = phys(head_ff, w_ff[PW-1:0]);
               wr_data = rd_data;
               w_in    = w_ff + CW'(1);
            end
            i_in     = i_ff + CW'(1);
            state_in = S_RM_RD;
         end
         // read out: one beat per entry
         S_RD_RD: begin
            rd_addr  = phys(head_ff, i_ff[PW-1:0]);
            state_in = S_RD_EX;
         end
         S_RD_EX: begin
            valid_in = 1'b1;
            elem_in  = rd_data;
            last_in  = ((i_ff + CW'(1)) == count_ff);
            i_in     = i_ff + CW'(1);
            state_in = last_in ? S_IDLE : S_RD_RD;
         end
         // exchange sort: entry i held in ei while j sweeps the list
         S_SO_RI: begin
            if (i_ff == count_ff) begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_addr  = phys(head_ff, i_ff[PW-1:0]);
               state_in = S_SO_LI;
            end
         end
         S_SO_LI: begin
            ei_in    = rd_data;
            j_in     = '0;
            state_in = S_SO_RJ;
         end
         S_SO_RJ: begin
            if (j_ff == count_ff) begin
               state_in = S_SO_WB;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CW'(1);
            end else begin
               rd_addr  = phys(head_ff, j_ff[PW-1:0]);
               state_in = S_SO_EX;
            end
         end
         S_SO_EX: begin
            if ($signed(rd_data) > $signed(ei_ff)) begin
               wr_en   = 1'b1;
               wr_addr = phys(head_ff, j_ff[PW-1:0]);
               wr_data = ei_ff;
               ei_in   = rd_data;
            end
            j_in     = j_ff + CW'(1);
            state_in = S_SO_RJ;
         end
         S_SO_WB: begin
            wr_en    = 1'b1;
            wr_addr  = phys(head_ff, i_ff[PW-1:0]);
            wr_data  = ei_ff;
            i_in     = i_ff + CW'(1);
            state_in = S_SO_RI;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      w_ff      <= w_in;
      val_ff    <= val_in;
      ei_ff     <= ei_in;
      status_ff <= status_in;
      elem_ff   <= elem_in;
      last_ff   <= last_in;
   end

   // result ports
   assign elem_ext          = 64'($signed(elem_ff));
   assign count_ext         = 64'(count_ff);
   assign rsp_strobe        = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_value = elem_ext[ELEM_W-1:0];
   assign rsp_entry_count   = count_ext[COUNT_W-1:0];
   assign rsp_last          = last_ff;

   // terms for the checks
   assign full_beat = rsp_strobe && (rsp_status == ST_FULL);
   assign walk_cmd  = accept && (req_opcode == OP_REMOVE || req_opcode == OP_SORT ||
                                 (req_opcode == OP_READ && count_ff != '0));

   // checks
   `BILE_ASSERT(a_count_bound, clock, reset, count_ff <= FULL_P)
   `BILE_ASSERT(a_mid_beat_busy, clock, reset, (rsp_strobe && !rsp_last) |-> busy)
   `BILE_ASSERT(a_full_only_full, clock, reset, full_beat |-> (count_ff == FULL_P))
   `BILE_ASSERT_NEXT(a_walk_busy, clock, reset, walk_cmd, busy)
endmodule
`default_nettype wire

// ===== hdl/bile_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module bile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== sim/tb_bounded_int_list_engine_unit.sv =====
// self-checking testbench for the bounded integer list engine: directed table, then random
// commands, each beat checked against a behavioral list model; depends on bile_pkg and the rtl
`default_nettype none
module tb_bounded_int_list_engine_unit;
   import bile_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int ITEM_TOTAL = 280;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic signed [ELEM_W-1:0] elem;
      logic [COUNT_W-1:0]     count;
      logic                   last;
   } list_beat_type;

   typedef struct {
      logic [OPCODE_W-1:0]    op;
      logic signed [ELEM_W-1:0] val;
      bit                     known;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_W-1:0]     count;
   } cmd_row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [OPCODE_W-1:0]    req_opcode;
   logic signed [ELEM_W-1:0] req_operand_value;
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic signed [ELEM_W-1:0] rsp_element_value;
   logic [COUNT_W-1:0]     rsp_entry_count;
   logic                   rsp_last;

   // shadow copy of the list and the beats still owed by the block
   logic signed [ELEM_W-1:0] shadow_list[LIST_DEPTH];
   int                     shadow_len;
   list_beat_type          owed_beats[$];
   int                     mismatches;
   int                     idle_pct;
   int                     n_issued;

   bounded_int_list_engine_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_operand_value(req_operand_value),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status),
      .rsp_element_value(rsp_element_value), .rsp_entry_count(rsp_entry_count),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // apply one command to the shadow list and queue the beats it should produce
   task automatic apply_list_cmd(input logic [OPCODE_W-1:0] op,
                                 input logic signed [ELEM_W-1:0] val);
      list_beat_type b;
      logic signed [ELEM_W-1:0] t;
      int w;
      b.status = ST_OK;
      b.elem   = '0;
      b.last   = 1'b1;
      case (op)
         OP_APPEND: begin
            if (shadow_len >= LIST_DEPTH) b.status = ST_FULL;
            else begin
               shadow_list[shadow_len] = val;
               shadow_len++;
            end
         end
         OP_INSERT: begin
            if (shadow_len >= LIST_DEPTH) b.status = ST_FULL;
            else begin
               for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[0] = val;
               shadow_len++;
            end
         end
         OP_REMOVE: begin
            w = 0;
            for (int i = 0; i < shadow_len; i++)
               if (shadow_list[i] != val) begin
                  shadow_list[w] = shadow_list[i];
                  w++;
               end
            shadow_len = w;
         end
         OP_POP: begin
            if (shadow_len > 0) begin
               for (int i = 0; i < shadow_len - 1; i++) shadow_list[i] = shadow_list[i+1];
               shadow_len--;
            end
         end
         OP_CLEAR: shadow_len = 0;
         OP_SORT: begin
            for (int i = 0; i < shadow_len; i++)
               for (int j = 0; j < shadow_len; j++)
                  if (shadow_list[j] > shadow_list[i]) begin
                     t = shadow_list[i];
                     shadow_list[i] = shadow_list[j];
                     shadow_list[j] = t;
                  end
         end
         default: ;
      endcase
      b.count = shadow_len[COUNT_W-1:0];
      if (op == OP_READ && shadow_len > 0) begin
         for (int i = 0; i < shadow_len; i++) begin
            b.elem = shadow_list[i];
            b.last = (i + 1 == shadow_len);
            owed_beats.push_back(b);
         end
      end else begin
         if (op == OP_READ) b.status = ST_EMPTY;
         owed_beats.push_back(b);
      end
   endtask

   // present one command, hold it until taken, then update the model
   task automatic issue_cmd(input logic [OPCODE_W-1:0] op, input logic signed [ELEM_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= op;
      req_operand_value <= val;
      do @(posedge clock); while (busy);
      n_issued++;
      apply_list_cmd(op, val);
   endtask

   // value pool: mostly a few repeats so remove and sort see duplicates
   function automatic logic signed [ELEM_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return ($urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000);
         default: return $signed($urandom_range(6)) - 3;
      endcase
   endfunction

   // check each result beat against the oldest owed one
   always @(posedge clock) begin
      list_beat_type e;
      if (!reset && rsp_strobe) begin
         if (owed_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat, status %0d", rsp_status);
         end else begin
            e = owed_beats.pop_front();
            if (rsp_status !== e.status || rsp_element_value !== e.elem ||
                rsp_entry_count !== e.count || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"beat differs: exp st %0d val %0d cnt %0d last %0d, ",
                            "got %0d %0d %0d %0d"},
                           e.status, e.elem, e.count, e.last, rsp_status, rsp_element_value,
                           rsp_entry_count, rsp_last);
            end
         end
      end
   end

   // run limit
   initial begin
      #300_000_000;
      $display("bounded_int_list_engine_unit: mismatch");
      $finish;
   end

   initial begin
      cmd_row_type dir_rows[$];
      list_beat_type known_beat;
      logic [OPCODE_W-1:0] op;
      int wait_cycles;
      mismatches = 0;
      shadow_len = 0;
      n_issued   = 0;
      idle_pct   = 6;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_opcode        <= OP_APPEND;
      req_operand_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table: known rows carry their expected status and count
      dir_rows = '{
         '{OP_READ,   32'sd0,          1, ST_EMPTY, 7'd0},
         '{OP_POP,    32'sd0,          1, ST_OK,    7'd0},
         '{OP_REMOVE, 32'sd5,          1, ST_OK,    7'd0},
         '{OP_SORT,   32'sd0,          1, ST_OK,    7'd0},
         '{OP_APPEND, 32'sh7fff_ffff,  1, ST_OK,    7'd1},
         '{OP_INSERT, 32'sh8000_0000,  1, ST_OK,    7'd2},
         '{OP_APPEND, 32'sd0,          1, ST_OK,    7'd3},
         '{OP_APPEND, -32'sd1,         1, ST_OK,    7'd4},
         '{OP_INSERT, 32'sh5555_aaaa,  1, ST_OK,    7'd5},
         '{OP_APPEND, -32'sd1,         1, ST_OK,    7'd6},
         '{OP_READ,   32'sd0,          0, ST_OK,    7'd0},
         '{OP_REMOVE, 32'sd12345,      1, ST_OK,    7'd6},
         '{OP_REMOVE, -32'sd1,         1, ST_OK,    7'd4},
         '{OP_SORT,   32'sd0,          1, ST_OK,    7'd4},
         '{OP_READ,   32'sd0,          0, ST_OK,    7'd0},
         '{OP_UNUSED, 32'sd99,         1, ST_OK,    7'd4},
         '{OP_POP,    32'sd0,          1, ST_OK,    7'd3},
         '{OP_READ,   32'sd0,          0, ST_OK,    7'd0},
         '{OP_CLEAR,  32'sd0,          1, ST_OK,    7'd0},
         '{OP_READ,   32'sd0,          1, ST_EMPTY, 7'd0}
      };
      foreach (dir_rows[r]) begin
         issue_cmd(dir_rows[r].op, dir_rows[r].val);
         if (dir_rows[r].known) begin
            known_beat = owed_beats.pop_back();
            known_beat.status = dir_rows[r].status;
            known_beat.count  = dir_rows[r].count;
            owed_beats.push_back(known_beat);
         end
      end

      // random part: three idle phases, with bursts that fill the list to full and then push once more
      while (n_issued < ITEM_TOTAL) begin
         idle_pct = (n_issued < ITEM_TOTAL / 3) ? 6 : (n_issued < 2 * ITEM_TOTAL / 3) ? 79 : 0;
         if ($urandom_range(39) == 0) begin
            while (shadow_len < LIST_DEPTH)
               issue_cmd($urandom_range(1) ? OP_APPEND : OP_INSERT, pick_value());
            issue_cmd($urandom_range(1) ? OP_APPEND : OP_INSERT, pick_value());
         end
         case ($urandom_range(19))
            0, 1, 2, 3, 4, 5: op = OP_APPEND;
            6, 7, 8:          op = OP_INSERT;
            9, 10:            op = OP_REMOVE;
            11, 12:           op = OP_POP;
            13:               op = OP_CLEAR;
            14, 15:           op = OP_SORT;
            16, 17:           op = OP_READ;
            default:          op = ($urandom_range(1)) ? OP_UNUSED : OP_READ;
         endcase
         issue_cmd(op, pick_value());
      end
      start <= 1'b0;

      // drain, then a short quiet window for stray beats
      wait_cycles = 0;
      while (owed_beats.size() != 0 && wait_cycles < 200_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && owed_beats.size() == 0)
         $display("bounded_int_list_engine_unit: match");
      else
         $display("bounded_int_list_engine_unit: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/bile_pkg.sv
hdl/bile_ram.sv
hdl/bounded_int_list_engine_unit.sv
sim/tb_bounded_int_list_engine_unit.sv
